[src/pfe_pkg.sv]
// Shared constants, register codes and item types for the Playfair digraph encryptor.
// No dependencies; the top level imports this package.
package pfe_pkg;

   localparam int LETTER_W          = 5;
   localparam int SQ_CELLS          = 25;
   localparam int GRID_SIDE_DEFAULT = 5;
   localparam int CSR_DATA_W        = 50;
   localparam int CSR_INDEX_W       = 3;
   localparam int CELLS_LOW_W       = 50;
   localparam int CELLS_TOP_W       = 25;
   localparam int PAIR_DEPTH        = 4;
   localparam int LETTER_DEPTH      = 8;

   localparam logic [LETTER_W-1:0] MERGED_FIRST_RST  = 5'd3;
   localparam logic [LETTER_W-1:0] MERGED_SECOND_RST = 5'd11;
   localparam logic [LETTER_W-1:0] PAD_LETTER_RST    = 5'd23;
   localparam logic [LETTER_W-1:0] EMPTY_CELL_CODE   = 5'd31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CELLS_LOW     = 3'd0,
      CSR_CELLS_MID     = 3'd1,
      CSR_CELLS_TOP     = 3'd2,
      CSR_MERGED_FIRST  = 3'd3,
      CSR_MERGED_SECOND = 3'd4,
      CSR_PAD_LETTER    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                last;
   } pair_type;

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic                last;
   } cipher_type;

   // Both letters of the merged pair map onto the first one.
   function automatic logic [LETTER_W-1:0] merge_letter(input logic [LETTER_W-1:0] l,
                                                        input logic [LETTER_W-1:0] mf,
                                                        input logic [LETTER_W-1:0] ms);
      return (l == mf || l == ms) ? mf : l;
   endfunction

endpackage

[src/playfair_digraph_encryptor_unit.sv]
// Top level of the Playfair digraph encryptor: digraph grouping, pair queue,
// square lookup pipeline and cipher letter queue. Depends on pfe_pkg.
//
// Usage: plaintext letters enter on the req_ channel, one item per letter, with
// req_tlast marking the last letter of a message. Cipher letters leave on the
// rsp_ channel, one item per letter, with rsp_tlast on the final one. The csr_
// port writes the key square, the merged letter pair and the pad letter; the
// user must write it only while the block is idle; the block does not enforce it.
// Throughput: an input item is accepted in every cycle while the pair queue has
// room for two digraphs; while rsp_tready is high the response side delivers
// one cipher letter per cycle, so the output channel sets the sustained rate
// (about one item per cycle for typical text, up to four result letters for a
// doubled final letter). A digraph completed by an accepted item is written to
// the pair queue, loaded into the match stage when the letter queue has room,
// and the lookup stage then writes its two cipher letters to the letter queue.
// Reset clears the held letter, both queues and the pipeline, and loads the
// register reset values (all-zero square, merged pair 3 and 11, pad 23).
// When the receiver stalls, cipher letters collect in the letter queue, the
// lookup stage stops taking digraphs and, once fewer than two pair queue slots
// are free, req_tready falls; nothing is dropped.
module playfair_digraph_encryptor_unit
   import pfe_pkg::*;
#(
   parameter int GRID_SIDE = GRID_SIDE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [4:0] plain_letter, [7:5] zero
   input  logic                   req_tlast,   // end_of_text
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [4:0] cipher_letter, [7:5] zero
   output logic                   rsp_tlast,   // last_cipher
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CELLS  = GRID_SIDE * GRID_SIDE;
   localparam int IDX_W  = $clog2(CELLS);
   localparam int POS_W  = $clog2(GRID_SIDE);
   localparam int PPTR_W = $clog2(PAIR_DEPTH);
   localparam int PCNT_W = $clog2(PAIR_DEPTH + 1);
   localparam int LPTR_W = $clog2(LETTER_DEPTH);
   localparam int LCNT_W = $clog2(LETTER_DEPTH + 1);

   // Configuration registers.
   logic [CELLS_LOW_W-1:0] cells_low_ff, cells_mid_ff;
   logic [CELLS_TOP_W-1:0] cells_top_ff;
   logic [LETTER_W-1:0]    merged_first_ff, merged_second_ff, pad_letter_ff;

   // Digraph grouping state.
   logic [LETTER_W-1:0] held_letter_ff, held_letter_in;
   logic                held_valid_ff, held_valid_in;

   // Pair queue.
   pair_type            pair_q_ff [PAIR_DEPTH];
   logic [PPTR_W-1:0]   pwr_ptr_ff, prd_ptr_ff;
   logic [PCNT_W-1:0]   pcount_ff, pcount_in;

   // Match stage.
   logic                s1_valid_ff;
   logic                s1_last_ff;
   logic [CELLS-1:0]    s1_match_a_ff, s1_match_b_ff;

   // Cipher letter queue.
   cipher_type          letter_q_ff [LETTER_DEPTH];
   logic [LPTR_W-1:0]   lwr_ptr_ff, lrd_ptr_ff;
   logic [LCNT_W-1:0]   lcount_ff, lcount_in;

   // The key square as an array of cells; cells past the registers read as empty.
   logic [3*CELLS_LOW_W/2+CELLS_TOP_W+CELLS_LOW_W/2-1:0] sq_all;
   logic [LETTER_W-1:0] cell_arr [CELLS];

   assign sq_all = {cells_top_ff, cells_mid_ff, cells_low_ff};

   for (genvar k = 0; k < CELLS; k++) begin : g_cells
      if (k < SQ_CELLS) begin : g_reg
         assign cell_arr[k] = sq_all[LETTER_W*k +: LETTER_W];
      end else begin : g_empty
         assign cell_arr[k] = EMPTY_CELL_CODE;
      end
   end

   // ---------------------------------------------------------------------
   // Input side: merge the letter and form up to two digraphs per item.
   // ---------------------------------------------------------------------
   logic                req_fire;
   logic [LETTER_W-1:0] merged, pad_merged;
   pair_type            push_a, push_b;
   logic [1:0]          push_n;

   assign req_tready = (pcount_ff <= PCNT_W'(PAIR_DEPTH - 2));
   assign req_fire   = req_tvalid & req_tready;
   assign merged     = merge_letter(req_tdata[LETTER_W-1:0], merged_first_ff,
                                    merged_second_ff);
   assign pad_merged = merge_letter(pad_letter_ff, merged_first_ff, merged_second_ff);

   always_comb begin
      held_letter_in = held_letter_ff;
      held_valid_in  = held_valid_ff;
      push_a         = '{first: merged, second: pad_merged, last: 1'b1};
      push_b         = '{first: merged, second: pad_merged, last: 1'b1};
      push_n         = 2'd0;
      if (req_fire) begin
         if (!held_valid_ff) begin
            if (req_tlast) begin
               push_n = 2'd1;
            end else begin
               held_letter_in = merged;
               held_valid_in  = 1'b1;
            end
         end else if (merged == held_letter_ff) begin
            // A doubled letter: pad the held one and let the new one start over.
            push_a = '{first: held_letter_ff, second: pad_merged, last: 1'b0};
            if (req_tlast) begin
               push_n        = 2'd2;
               held_valid_in = 1'b0;
            end else begin
               push_n         = 2'd1;
               held_letter_in = merged;
            end
         end else begin
            push_a        = '{first: held_letter_ff, second: merged, last: req_tlast};
            push_n        = 2'd1;
            held_valid_in = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Match stage: compare both letters of the head digraph with every cell.
   // ---------------------------------------------------------------------
   logic                  pair_pop;
   logic [LCNT_W:0]       letters_committed;
   pair_type              pair_head;
   logic [CELLS-1:0]      match_a, match_b;

   assign letters_committed = (LCNT_W + 1)'(lcount_ff) +
                              (s1_valid_ff ? (LCNT_W + 1)'(2) : '0);
   assign pair_pop  = (pcount_ff != '0) &&
                      (letters_committed <= (LCNT_W + 1)'(LETTER_DEPTH - 2));
   assign pair_head = pair_q_ff[prd_ptr_ff];

   always_comb begin
      for (int k = 0; k < CELLS; k++) begin
         match_a[k] = (cell_arr[k] == pair_head.first);
         match_b[k] = (cell_arr[k] == pair_head.second);
      end
   end

   // ---------------------------------------------------------------------
   // Lookup stage: position of the highest matching cell, Playfair rules,
   // then read of the two cipher cells.
   // ---------------------------------------------------------------------
   logic [POS_W-1:0] row_a, col_a, row_b, col_b;
   logic [POS_W-1:0] nrow_a, ncol_a, nrow_b, ncol_b;
   logic [IDX_W-1:0] idx_a, idx_b;
   cipher_type       out_a, out_b;

   function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] v);
      return (v == POS_W'(GRID_SIDE - 1)) ? '0 : v + 1'b1;
   endfunction

   always_comb begin
      // A letter missing from the square falls back to cell zero.
      row_a = '0;
      col_a = '0;
      row_b = '0;
      col_b = '0;
      for (int r = 0; r < GRID_SIDE; r++) begin
         for (int c = 0; c < GRID_SIDE; c++) begin
            if (s1_match_a_ff[r*GRID_SIDE + c]) begin
               row_a = POS_W'(r);
               col_a = POS_W'(c);
            end
            if (s1_match_b_ff[r*GRID_SIDE + c]) begin
               row_b = POS_W'(r);
               col_b = POS_W'(c);
            end
         end
      end
   end

   always_comb begin
      nrow_a = row_a;
      ncol_a = col_a;
      nrow_b = row_b;
      ncol_b = col_b;
      if (col_a == col_b) begin
         nrow_a = wrap_inc(row_a);
         nrow_b = wrap_inc(row_b);
      end else if (row_a == row_b) begin
         ncol_a = wrap_inc(col_a);
         ncol_b = wrap_inc(col_b);
      end else begin
         ncol_a = col_b;
         ncol_b = col_a;
      end
   end

   assign idx_a = IDX_W'(nrow_a) * IDX_W'(GRID_SIDE) + IDX_W'(ncol_a);
   assign idx_b = IDX_W'(nrow_b) * IDX_W'(GRID_SIDE) + IDX_W'(ncol_b);
   assign out_a = '{letter: cell_arr[idx_a], last: 1'b0};
   assign out_b = '{letter: cell_arr[idx_b], last: s1_last_ff};

   // ---------------------------------------------------------------------
   // Output side.
   // ---------------------------------------------------------------------
   logic rsp_fire;

   assign rsp_tvalid = (lcount_ff != '0);
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {3'b000, letter_q_ff[lrd_ptr_ff].letter};
   assign rsp_tlast  = letter_q_ff[lrd_ptr_ff].last;

   assign pcount_in = pcount_ff + PCNT_W'(push_n) - PCNT_W'(pair_pop);
   assign lcount_in = lcount_ff + (s1_valid_ff ? LCNT_W'(2) : '0) - LCNT_W'(rsp_fire);

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_low_ff     <= '0;
         cells_mid_ff     <= '0;
         cells_top_ff     <= '0;
         merged_first_ff  <= MERGED_FIRST_RST;
         merged_second_ff <= MERGED_SECOND_RST;
         pad_letter_ff    <= PAD_LETTER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CELLS_LOW:     cells_low_ff     <= csr_wdata[CELLS_LOW_W-1:0];
            CSR_CELLS_MID:     cells_mid_ff     <= csr_wdata[CELLS_LOW_W-1:0];
            CSR_CELLS_TOP:     cells_top_ff     <= csr_wdata[CELLS_TOP_W-1:0];
            CSR_MERGED_FIRST:  merged_first_ff  <= csr_wdata[LETTER_W-1:0];
            CSR_MERGED_SECOND: merged_second_ff <= csr_wdata[LETTER_W-1:0];
            CSR_PAD_LETTER:    pad_letter_ff    <= csr_wdata[LETTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pwr_ptr_ff    <= '0;
         prd_ptr_ff    <= '0;
         pcount_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         lwr_ptr_ff    <= '0;
         lrd_ptr_ff    <= '0;
         lcount_ff     <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         pcount_ff     <= pcount_in;
         pwr_ptr_ff    <= pwr_ptr_ff + PPTR_W'(push_n);
         if (pair_pop) begin
            prd_ptr_ff <= prd_ptr_ff + 1'b1;
         end
         s1_valid_ff <= pair_pop;
         lcount_ff   <= lcount_in;
         if (s1_valid_ff) begin
            lwr_ptr_ff <= lwr_ptr_ff + LPTR_W'(2);
         end
         if (rsp_fire) begin
            lrd_ptr_ff <= lrd_ptr_ff + 1'b1;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      held_letter_ff <= held_letter_in;
      if (push_n != 2'd0) begin
         pair_q_ff[pwr_ptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         pair_q_ff[pwr_ptr_ff + 1'b1] <= push_b;
      end
      if (pair_pop) begin
         s1_match_a_ff <= match_a;
         s1_match_b_ff <= match_b;
         s1_last_ff    <= pair_head.last;
      end
      if (s1_valid_ff) begin
         letter_q_ff[lwr_ptr_ff]        <= out_a;
         letter_q_ff[lwr_ptr_ff + 1'b1] <= out_b;
      end
   end

`ifndef NO_ASSERTIONS
   a_pair_queue_bound: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= PCNT_W'(PAIR_DEPTH))
      else $error("pair queue overflow");

   a_letter_queue_bound: assert property (@(posedge clock) disable iff (reset)
      lcount_ff <= LCNT_W'(LETTER_DEPTH))
      else $error("cipher letter queue overflow");

   a_lookup_has_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (lcount_ff <= LCNT_W'(LETTER_DEPTH - 2)))
      else $error("lookup stage started without room for two letters");

   a_digraph_closes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && held_valid_ff && merged != held_letter_ff) |=> !held_valid_ff)
      else $error("held letter not released after a completed digraph");
`endif

endmodule

[tb/playfair_digraph_encryptor_unit_tb.sv]
// Self-checking testbench for playfair_digraph_encryptor_unit: streams plaintext messages,
// predicts every cipher letter in a scoreboard class and compares them in order.
// Depends on pfe_pkg and the RTL top level only.
`timescale 1ns / 100ps

module playfair_digraph_encryptor_unit_tb;
   import pfe_pkg::*;

   localparam int GRID = GRID_SIDE_DEFAULT;
   // The settle time leaves a wide margin on top of the time that the RTL takes
   // from an accepted item to its first cipher letter.
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_PERCENT = 32;
   localparam int MAX_REPORTS = 10;
   // An index that names no register; a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;

   // Scoreboard: a bit-exact copy of the cipher behavior plus the queue of
   // cipher letters that the block still owes.
   class cipher_scoreboard;
      logic [LETTER_W-1:0] square [SQ_CELLS];
      logic [LETTER_W-1:0] merge_first, merge_second, pad;
      logic [LETTER_W-1:0] held;
      bit                  held_ok;
      cipher_type          cipher_due [$];
      int                  failures;

      function new();
         foreach (square[i]) square[i] = '0;
         merge_first  = MERGED_FIRST_RST;
         merge_second = MERGED_SECOND_RST;
         pad          = PAD_LETTER_RST;
         held         = '0;
         held_ok      = 1'b0;
         failures     = 0;
      endfunction

      function int pending();
         return cipher_due.size();
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_CELLS_LOW:     for (int i = 0; i < 10; i++) square[i] = v[5*i +: 5];
            CSR_CELLS_MID:     for (int i = 0; i < 10; i++) square[10+i] = v[5*i +: 5];
            CSR_CELLS_TOP:     for (int i = 0; i < 5; i++) square[20+i] = v[5*i +: 5];
            CSR_MERGED_FIRST:  merge_first = v[LETTER_W-1:0];
            CSR_MERGED_SECOND: merge_second = v[LETTER_W-1:0];
            CSR_PAD_LETTER:    pad = v[LETTER_W-1:0];
            default: ;
         endcase
      endfunction

      // Cells past the register bank read as the empty code.
      function logic [LETTER_W-1:0] cell_at(input int k);
         return (k < SQ_CELLS) ? square[k] : EMPTY_CELL_CODE;
      endfunction

      function logic [LETTER_W-1:0] fold_pair(input logic [LETTER_W-1:0] l);
         return (l == merge_first || l == merge_second) ? merge_first : l;
      endfunction

      // The last matching cell wins; a letter found nowhere lands in cell 0.
      function int find_cell(input logic [LETTER_W-1:0] l);
         int hit;
         hit = 0;
         for (int k = 0; k < GRID * GRID; k++)
            if (cell_at(k) == l) hit = k;
         return hit;
      endfunction

      function void push_digraph(input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b,
                                 input logic last);
         int         r1, c1, r2, c2, t;
         cipher_type c;
         r1 = find_cell(a) / GRID;
         c1 = find_cell(a) % GRID;
         r2 = find_cell(b) / GRID;
         c2 = find_cell(b) % GRID;
         if (c1 == c2) begin
            r1 = (r1 + 1) % GRID;
            r2 = (r2 + 1) % GRID;
         end else if (r1 == r2) begin
            c1 = (c1 + 1) % GRID;
            c2 = (c2 + 1) % GRID;
         end else begin
            t  = c1;
            c1 = c2;
            c2 = t;
         end
         c.letter = cell_at(r1 * GRID + c1);
         c.last   = 1'b0;
         cipher_due.insert(cipher_due.size(), c);
         c.letter = cell_at(r2 * GRID + c2);
         c.last   = last;
         cipher_due.insert(cipher_due.size(), c);
      endfunction

      // Called for every accepted plaintext item.
      function void note_plain_letter(input logic [LETTER_W-1:0] l, input logic eot);
         logic [LETTER_W-1:0] m, p;
         m = fold_pair(l);
         p = fold_pair(pad);
         if (!held_ok) begin
            if (eot) begin
               push_digraph(m, p, 1'b1);
            end else begin
               held    = m;
               held_ok = 1'b1;
            end
         end else if (m == held) begin
            // A doubled letter: pad the open digraph and restart with the repeat.
            push_digraph(held, p, 1'b0);
            if (eot) begin
               push_digraph(m, p, 1'b1);
               held_ok = 1'b0;
               held    = '0;
            end else begin
               held = m;
            end
         end else begin
            push_digraph(held, m, eot);
            held_ok = 1'b0;
            held    = '0;
         end
      endfunction

      // Called for every accepted cipher item.
      function void check_cipher_letter(input logic [LETTER_W-1:0] l, input logic last);
         cipher_type c;
         if (cipher_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected cipher letter %0d last %0b", $realtime, l, last);
            return;
         end
         c = cipher_due.pop_front();
         if (c.letter !== l || c.last !== last) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"%0t: cipher mismatch: expected letter %0d last %0b, ",
                         "got letter %0d last %0b"},
                        $realtime, c.letter, c.last, l, last);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [4:0] plain_letter, [7:5] zero
   logic                   req_tlast;   // end_of_text
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [4:0] cipher_letter, [7:5] zero
   logic                   rsp_tlast;   // last_cipher
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cipher_scoreboard    board;
   bit                  req_idle_on;
   bit                  rsp_idle_on;
   logic [LETTER_W-1:0] key_cells [SQ_CELLS];
   // Copies of the current merged pair and pad, used to steer random text.
   logic [LETTER_W-1:0] cfg_first, cfg_second, cfg_pad;

   playfair_digraph_encryptor_unit #(
      .GRID_SIDE (GRID)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random while idling is enabled. Its ready changes
   // only at the falling edge, so the monitor sees a stable value.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= !rsp_idle_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Sampling at the rising edge reads the values from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_cipher_letter(rsp_tdata[LETTER_W-1:0], rsp_tlast);
   end

   // Offers one plaintext item, with optional idle cycles in front of it, and
   // returns at the falling edge after the item was taken. Valid is only lowered
   // when an idle cycle follows, so it never toggles within one time step.
   task automatic send_letter(input logic [LETTER_W-1:0] l, input logic eot);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, l};
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_plain_letter(l, eot);
      @(negedge clock);
   endtask

   // Drives one register write. The enable stays high so that writes can come
   // back to back; program_key lowers it after the last one.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.write_reg(idx, v);
      @(negedge clock);
   endtask

   // Writes every register from key_cells and the given letters. Bits above a
   // register's width carry junk, which the block has to ignore.
   task automatic program_key(input logic [LETTER_W-1:0] first_l,
                              input logic [LETTER_W-1:0] second_l,
                              input logic [LETTER_W-1:0] pad_l);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'({$urandom, $urandom});
      for (int i = 0; i < 10; i++) v[5*i +: 5] = key_cells[i];
      write_csr(CSR_CELLS_LOW, v);
      for (int i = 0; i < 10; i++) v[5*i +: 5] = key_cells[10+i];
      write_csr(CSR_CELLS_MID, v);
      v = CSR_DATA_W'({$urandom, $urandom});
      for (int i = 0; i < 5; i++) v[5*i +: 5] = key_cells[20+i];
      write_csr(CSR_CELLS_TOP, v);
      v = CSR_DATA_W'({$urandom, $urandom});
      v[LETTER_W-1:0] = first_l;
      write_csr(CSR_MERGED_FIRST, v);
      v[LETTER_W-1:0] = second_l;
      write_csr(CSR_MERGED_SECOND, v);
      v[LETTER_W-1:0] = pad_l;
      write_csr(CSR_PAD_LETTER, v);
      write_csr(CSR_NO_REGISTER, CSR_DATA_W'({$urandom, $urandom}));
      csr_we     <= 1'b0;
      cfg_first  = first_l;
      cfg_second = second_l;
      cfg_pad    = pad_l;
   endtask

   // Fills the square with the 25 letters other than skip, either in
   // alphabetical order or shuffled.
   task automatic fill_key_square(input logic [LETTER_W-1:0] skip, input bit shuffle);
      logic [LETTER_W-1:0] pool [$];
      logic [LETTER_W-1:0] t;
      int                  j;
      for (int v = 0; v < 26; v++)
         if (v != skip) pool.insert(pool.size(), LETTER_W'(v));
      if (shuffle) begin
         for (int i = pool.size() - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            t       = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
         end
      end
      for (int i = 0; i < SQ_CELLS; i++) key_cells[i] = pool[i];
   endtask

   // Random messages of one to nine letters. Doubles and the merged and pad
   // letters come up often, since they drive the padding paths.
   task automatic send_random_text(input int n_items);
      int                  left, msg_left;
      logic [LETTER_W-1:0] l, prev;
      left = n_items;
      prev = '0;
      while (left > 0) begin
         msg_left = $urandom_range(1, 9);
         if (msg_left > left) msg_left = left;
         while (msg_left > 0) begin
            case ($urandom_range(9)) inside
               0, 1:    l = prev;
               2:       l = cfg_first;
               3:       l = cfg_second;
               4:       l = cfg_pad;
               default: l = LETTER_W'($urandom_range(25));
            endcase
            send_letter(l, msg_left == 1);
            prev = l;
            msg_left--;
            left--;
         end
      end
   endtask

   // Stops offering items and waits until the block owes nothing, then lets
   // the pipeline run empty before anything else happens.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      board       = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      cfg_first   = MERGED_FIRST_RST;
      cfg_second  = MERGED_SECOND_RST;
      cfg_pad     = PAD_LETTER_RST;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: an all-zero square, so letter 0 sits in the last cell
      // and every other letter falls back to cell 0.
      send_letter(5'd0, 1'b1);
      send_letter(5'd5, 1'b0);
      send_letter(5'd25, 1'b1);
      settle_block();

      // Alphabetical square without the merged second letter.
      fill_key_square(MERGED_SECOND_RST, 1'b0);
      program_key(MERGED_FIRST_RST, MERGED_SECOND_RST, PAD_LETTER_RST);
      send_letter(5'd0, 1'b0);     // same row, second letter wraps to column 0
      send_letter(5'd4, 1'b1);
      send_letter(5'd0, 1'b0);     // same column, second letter wraps to row 0
      send_letter(5'd21, 1'b1);
      send_letter(5'd7, 1'b0);     // rectangle
      send_letter(5'd19, 1'b1);
      send_letter(5'd25, 1'b1);    // one-letter message gets padded
      send_letter(5'd11, 1'b0);    // second merged letter doubles the first at the end
      send_letter(5'd3, 1'b1);
      send_letter(5'd5, 1'b0);     // double in the middle of a message
      send_letter(5'd5, 1'b0);
      send_letter(5'd9, 1'b1);
      send_letter(5'd23, 1'b0);    // doubled pad letter
      send_letter(5'd23, 1'b1);
      send_letter(5'd11, 1'b1);    // odd final letter that is a merged letter
      send_letter(5'd3, 1'b1);
      send_letter(5'd12, 1'b0);
      send_letter(5'd11, 1'b1);
      settle_block();

      // Shuffled square, random pair and pad, both sides idling.
      cfg_second = LETTER_W'($urandom_range(25));
      fill_key_square(cfg_second, 1'b1);
      program_key(LETTER_W'($urandom_range(25)), cfg_second,
                  LETTER_W'($urandom_range(25)));
      send_random_text(40);
      settle_block();

      // A long stretch with no idling on either side.
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      cfg_second  = LETTER_W'($urandom_range(25));
      fill_key_square(cfg_second, 1'b1);
      program_key(LETTER_W'($urandom_range(25)), cfg_second,
                  LETTER_W'($urandom_range(25)));
      send_random_text(40);
      settle_block();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;

      // Random cell codes: repeated letters, missing letters and codes above
      // the alphabet. Merged letters equal, pad on the merged letter.
      foreach (key_cells[i]) key_cells[i] = LETTER_W'($urandom_range(31));
      cfg_first = LETTER_W'($urandom_range(25));
      program_key(cfg_first, cfg_first, cfg_first);
      send_random_text(30);
      settle_block();

      // Every cell at the all-ones code: no letter is found at all.
      foreach (key_cells[i]) key_cells[i] = EMPTY_CELL_CODE;
      program_key(5'd25, 5'd0, 5'd0);
      send_random_text(20);
      settle_block();

      // Opposite extremes of the pair and the pad.
      fill_key_square(5'd25, 1'b1);
      program_key(5'd0, 5'd25, 5'd25);
      send_random_text(40);
      settle_block();

      if (board.failures == 0 && board.pending() == 0) begin
         $display("PASS playfair_digraph_encryptor_unit");
      end else begin
         $display("FAIL playfair_digraph_encryptor_unit");
      end
      $finish;
   end

   // Guard against a hung handshake; a correct run needs a small fraction of this.
   initial begin
      #400000;
      $display("FAIL playfair_digraph_encryptor_unit");
      $finish;
   end

endmodule

[sim.f]
src/pfe_pkg.sv
src/playfair_digraph_encryptor_unit.sv
tb/playfair_digraph_encryptor_unit_tb.sv
